### src/rarq_pkg.sv
// ----------------------------------------------------------------------------
// rarq_pkg
// Shared field widths and request codes for the range-add point-query tree.
// ----------------------------------------------------------------------------
package rarq_pkg;

  localparam int WORD_W  = 32;
  localparam int BOUND_W = 11;
  localparam int POS_W   = 10;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

endpackage

### src/rarq_store.sv
// ----------------------------------------------------------------------------
// rarq_store
// Node store of the tree: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rarq_store
  import rarq_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  word_t         wdata,
  input  logic [AW-1:0] raddr,
  output word_t         rdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/range_add_point_query_tree.sv
// ----------------------------------------------------------------------------
// range_add_point_query_tree
// Bottom-up segment tree: adds a signed amount over [left, right) or returns
// the accumulated value at one position. All sums wrap modulo 2^32.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | fields
//  ----------+----------------------+-------------------------------------
//  request   | start / busy         | mode, left, right, amount, position
//  result    | done (1-cycle strobe)| point_value
//
//  Add: each tree level takes the states ADD_LO, ADD_HI and, for an odd
//  right bound, ADD_HW; the single read port and the shared adder allow
//  one node read and one node write at a time. Query: one node read per
//  cycle up the leaf-to-root path. An out-of-range query answers 0 in the
//  cycle after it is taken. After reset a clearing pass zeroes all 2*LEAVES
//  nodes of the store with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module range_add_point_query_tree
  import rarq_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode,
  input  logic [BOUND_W-1:0]       left,
  input  logic [BOUND_W-1:0]       right,
  input  logic signed [WORD_W-1:0] amount,
  input  logic [POS_W-1:0]         position,
  output logic                     done,
  output logic signed [WORD_W-1:0] point_value
);

  localparam int DEPTH = 2 * LEAVES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(DEPTH + 1);
  localparam logic [31:0] L32 = 32'(LEAVES);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ADD_LO = 3'd2;
  localparam logic [2:0] S_ADD_HI = 3'd3;
  localparam logic [2:0] S_ADD_HW = 3'd4;
  localparam logic [2:0] S_QRY    = 3'd5;

  logic [2:0]    state;
  logic [AW-1:0] clr_cnt;
  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic [IW-1:0] hi_dec;
  logic [IW-1:0] lo_inc;
  logic [AW-1:0] idx;
  logic          pend;
  word_t         amt;
  word_t         sum;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  word_t         wdata;
  word_t         rdata;

  word_t         op_a;
  word_t         op_b;
  word_t         add_res;

  logic [31:0]   left_ext;
  logic [31:0]   right_ext;
  logic [31:0]   left_cl;
  logic [31:0]   right_cl;
  logic [IW-1:0] lo_init;
  logic [IW-1:0] hi_init;
  logic          pos_ok;
  logic [31:0]   leaf_ext;
  logic          accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // clamp bounds to the leaf count, then move to leaf indexes
  assign left_ext  = 32'(left);
  assign right_ext = 32'(right);
  assign left_cl   = (left_ext > L32) ? L32 : left_ext;
  assign right_cl  = (right_ext > L32) ? L32 : right_ext;
  assign lo_init   = IW'(left_cl + L32);
  assign hi_init   = IW'(right_cl + L32);
  assign pos_ok    = (32'(position) < L32);
  assign leaf_ext  = 32'(position) + L32;

  assign hi_dec = hi - IW'(1);
  assign lo_inc = lo + IW'(lo[0]);

  // shared adder: node update in add mode, running sum in query mode
  assign op_a    = (state == S_QRY) ? sum : amt;
  assign op_b    = (state == S_QRY && !pend) ? '0 : rdata;
  assign add_res = op_a + op_b;

  always_comb begin
    we    = 1'b0;
    waddr = lo[AW-1:0];
    wdata = add_res;
    raddr = lo[AW-1:0];
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      S_ADD_HI: begin
        we    = lo[0];
        raddr = hi_dec[AW-1:0];
      end
      S_ADD_HW: begin
        we    = 1'b1;
        waddr = hi_dec[AW-1:0];
      end
      S_QRY: begin
        raddr = idx;
      end
      default: begin
      end
    endcase
  end

  rarq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
      pend    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (mode == MODE_ADD) begin
              lo    <= lo_init;
              hi    <= hi_init;
              amt   <= amount;
              state <= S_ADD_LO;
            end else if (pos_ok) begin
              idx   <= leaf_ext[AW-1:0];
              sum   <= '0;
              pend  <= 1'b0;
              state <= S_QRY;
            end else begin
              done        <= 1'b1;
              point_value <= '0;
            end
          end
        end
        S_ADD_LO: begin
          if (lo >= hi) begin
            state <= S_IDLE;
          end else begin
            state <= S_ADD_HI;
          end
        end
        S_ADD_HI: begin
          // left node written this cycle if odd; right node read, used only if odd
          if (hi[0]) begin
            lo    <= lo_inc;
            state <= S_ADD_HW;
          end else begin
            lo    <= lo_inc >> 1;
            hi    <= hi >> 1;
            state <= S_ADD_LO;
          end
        end
        S_ADD_HW: begin
          lo    <= lo >> 1;
          hi    <= hi >> 1;
          state <= S_ADD_LO;
        end
        S_QRY: begin
          sum <= add_res;
          if (idx == '0) begin
            done        <= 1'b1;
            point_value <= add_res;
            state       <= S_IDLE;
          end else begin
            idx  <= idx >> 1;
            pend <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_QRY) || $past(accept && mode == MODE_QUERY))
    else $error("result strobe without a query");

  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> (state == S_CLEAR))
    else $error("clearing pass skipped after reset");

  a_no_node_zero: assert property (@(posedge clk) disable iff (rst)
    (we && state != S_CLEAR) |-> (waddr != '0))
    else $error("update written to unused node 0");

  a_right_write_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD_HW) |-> ($past(state) == S_ADD_HI) && $past(hi[0]))
    else $error("right node written without its read");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while a result is shown");

endmodule
